// ===== rtl/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants and controller/datapath interface types for the text
// console character writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = COLUMNS * ROWS;

	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;
	localparam int LOC_W  = 11;
	localparam int CHAR_W = 8;
	localparam int ATTR_W = 8;
	localparam int CELL_W = 16;

	localparam logic [LOC_W-1:0]  CELLS_L      = LOC_W'(CELLS);
	localparam logic [LOC_W-1:0]  COLUMNS_L    = LOC_W'(COLUMNS);
	localparam logic [LOC_W-1:0]  COPY_LAST_L  = LOC_W'(CELLS - COLUMNS - 1);
	localparam logic [LOC_W-1:0]  CELL_LAST_L  = LOC_W'(CELLS - 1);
	localparam logic [LOC_W-1:0]  LAST_ROW_LOC = LOC_W'((ROWS - 1) * COLUMNS);
	localparam logic [COL_W-1:0]  COL_LAST     = COL_W'(COLUMNS - 1);
	localparam logic [ROW_W-1:0]  ROW_LAST     = ROW_W'(ROWS - 1);

	localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
	localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
	localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h0F;

	localparam logic OP_PUT  = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef struct packed {
		logic in_load;
		logic put_exec;
		logic rd_issue;
		logic sweep_clr;
		logic clr_wr;
		logic copy_rd;
		logic blank_wr;
		logic out_load;
	} tcw_cmd_t;

	typedef struct packed {
		logic op_read;
		logic scroll_need;
		logic sweep_copy_last;
		logic sweep_last;
	} tcw_sts_t;

endpackage

// ===== rtl/text_console_char_writer_top.sv =====
// ----------------------------------------------------------------------------
// text_console_char_writer_top
// Text-mode console: puts characters at the cursor with wrap and scroll,
// and reads back single cells of the 80x25 cell store.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_stall    operation, char_code, cell_address
//   out      output     out_valid / out_stall  read_data, cursor_row, cursor_col,
//                                              cursor_location, scrolled
//   cfg      input      cfg_wr_en              cfg_wr_data (text attribute)
//
// a read or an ordinary put passes through the exec and finish states from accept to result
// a put that scrolls adds 1920 cell copies through the single
// store read port, a drain state and 80 blank writes
// after reset a clearing pass writes all 2000 cells, in_stall high meanwhile
// a new item is accepted while the previous result is still stalled
// ----------------------------------------------------------------------------
module text_console_char_writer_top
	import tcw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [ATTR_W-1:0] cfg_wr_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              operation,
	input  logic [CHAR_W-1:0] char_code,
	input  logic [LOC_W-1:0]  cell_address,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [CELL_W-1:0] read_data,
	output logic [ROW_W-1:0]  cursor_row,
	output logic [COL_W-1:0]  cursor_col,
	output logic [LOC_W-1:0]  cursor_location,
	output logic              scrolled
);

	tcw_cmd_t cmd;
	tcw_sts_t sts;

	tcw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	tcw_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.operation       (operation),
		.char_code       (char_code),
		.cell_address    (cell_address),
		.read_data       (read_data),
		.cursor_row      (cursor_row),
		.cursor_col      (cursor_col),
		.cursor_location (cursor_location),
		.scrolled        (scrolled)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input accepted twice in a row");

	a_loc_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (32'(cursor_location) ==
			32'(cursor_row) * 32'(COLUMNS) + 32'(cursor_col)))
		else $error("cursor location out of step with row and column");

	a_scroll_row: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && scrolled) |-> (cursor_row == ROW_LAST && cursor_col == '0))
		else $error("scroll left cursor off the start of the last row");

endmodule

// ===== rtl/tcw_dp.sv =====
// ----------------------------------------------------------------------------
// tcw_dp
// Datapath: cell store, cursor registers, attribute register, sweep counter
// for clear and scroll, and the output item registers.
// ----------------------------------------------------------------------------
module tcw_dp
	import tcw_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  tcw_cmd_t            cmd,
	output tcw_sts_t            sts,
	input  logic                cfg_wr_en,
	input  logic [ATTR_W-1:0]   cfg_wr_data,
	input  logic                operation,
	input  logic [CHAR_W-1:0]   char_code,
	input  logic [LOC_W-1:0]    cell_address,
	output logic [CELL_W-1:0]   read_data,
	output logic [ROW_W-1:0]    cursor_row,
	output logic [COL_W-1:0]    cursor_col,
	output logic [LOC_W-1:0]    cursor_location,
	output logic                scrolled
);

	logic [CELL_W-1:0] mem [CELLS];

	logic [ATTR_W-1:0] attr_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [LOC_W-1:0]  loc_q;
	logic [LOC_W-1:0]  sweep_q;
	logic              op_q;
	logic [CHAR_W-1:0] char_q;
	logic [LOC_W-1:0]  addr_q;
	logic              scr_q;
	logic [CELL_W-1:0] rd_q;
	logic              cp_vld_s1;
	logic [LOC_W-1:0]  cp_addr_s1;

	logic              is_nl;
	logic              is_pr;
	logic              wrap;
	logic              scroll;
	logic              addr_ok;
	logic [COL_W-1:0]  col_n;
	logic [ROW_W-1:0]  row_n;
	logic [LOC_W-1:0]  loc_n;
	logic              we;
	logic [LOC_W-1:0]  wa;
	logic [CELL_W-1:0] wd;
	logic              re;
	logic [LOC_W-1:0]  ra;

	assign is_nl   = (char_q == NEWLINE_CHAR);
	assign is_pr   = !char_q[7] && (char_q[6:5] != 2'b00);
	assign wrap    = is_nl || (is_pr && col_q == COL_LAST);
	assign scroll  = wrap && (row_q == ROW_LAST);
	assign addr_ok = (addr_q < CELLS_L);

	always_comb begin
		col_n = col_q;
		row_n = row_q;
		loc_n = loc_q;
		if (scroll) begin
			col_n = '0;
			row_n = ROW_LAST;
			loc_n = LAST_ROW_LOC;
		end else if (wrap) begin
			col_n = '0;
			row_n = row_q + ROW_W'(1);
			loc_n = loc_q - LOC_W'(col_q) + COLUMNS_L;
		end else if (is_pr) begin
			col_n = col_q + COL_W'(1);
			loc_n = loc_q + LOC_W'(1);
		end
	end

	assign sts.op_read         = (op_q == OP_READ);
	assign sts.scroll_need     = scroll;
	assign sts.sweep_copy_last = (sweep_q == COPY_LAST_L);
	assign sts.sweep_last      = (sweep_q == CELL_LAST_L);

	// one write port, one read port
	always_comb begin
		we = 1'b0;
		wa = sweep_q;
		wd = '0;
		if (cmd.clr_wr) begin
			we = 1'b1;
		end else if (cp_vld_s1) begin
			we = 1'b1;
			wa = cp_addr_s1;
			wd = rd_q;
		end else if (cmd.blank_wr) begin
			we = 1'b1;
			wd = {attr_q, BLANK_CHAR};
		end else if (cmd.put_exec && is_pr) begin
			we = 1'b1;
			wa = loc_q;
			wd = {attr_q, char_q};
		end
	end

	assign re = cmd.copy_rd || (cmd.rd_issue && addr_ok);
	assign ra = cmd.copy_rd ? (sweep_q + COLUMNS_L) : addr_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			rd_q <= mem[ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q    <= ATTR_RESET;
			col_q     <= '0;
			row_q     <= '0;
			loc_q     <= '0;
			sweep_q   <= '0;
			cp_vld_s1 <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				attr_q <= cfg_wr_data;
			end
			if (cmd.put_exec) begin
				col_q <= col_n;
				row_q <= row_n;
				loc_q <= loc_n;
			end
			if (cmd.sweep_clr) begin
				sweep_q <= '0;
			end else if (cmd.clr_wr || cmd.copy_rd || cmd.blank_wr) begin
				sweep_q <= sweep_q + LOC_W'(1);
			end
			cp_vld_s1 <= cmd.copy_rd;
		end
	end

	always_ff @(posedge clk) begin
		cp_addr_s1 <= sweep_q;
		if (cmd.in_load) begin
			op_q   <= operation;
			char_q <= char_code;
			addr_q <= cell_address;
			scr_q  <= 1'b0;
		end else if (cmd.put_exec) begin
			scr_q <= scroll;
		end
		if (cmd.out_load) begin
			read_data       <= (op_q == OP_READ && addr_ok) ? rd_q : '0;
			cursor_row      <= row_q;
			cursor_col      <= col_q;
			cursor_location <= loc_q;
			scrolled        <= scr_q;
		end
	end

endmodule

// ===== rtl/tcw_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcw_ctrl
// Controller: clearing pass after reset, item sequencing, scroll sweep and
// output item handshake.
// ----------------------------------------------------------------------------
module tcw_ctrl
	import tcw_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  tcw_sts_t sts,
	output tcw_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_COPY,
		ST_DRAIN,
		ST_BLANK,
		ST_FIN
	} state_t;

	state_t state_q;
	logic   out_free;

	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid || !out_stall;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_CLEAR: cmd.clr_wr = 1'b1;
			ST_IDLE:  cmd.in_load = in_valid;
			ST_EXEC: begin
				if (sts.op_read) begin
					cmd.rd_issue = 1'b1;
				end else begin
					cmd.put_exec  = 1'b1;
					cmd.sweep_clr = sts.scroll_need;
				end
			end
			ST_COPY:  cmd.copy_rd = 1'b1;
			ST_DRAIN: cmd = '0;
			ST_BLANK: cmd.blank_wr = 1'b1;
			ST_FIN:   cmd.out_load = out_free;
			default:  cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			out_valid <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (sts.sweep_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (!sts.op_read && sts.scroll_need) begin
						state_q <= ST_COPY;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_COPY: begin
					if (sts.sweep_copy_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: state_q <= ST_BLANK;
				ST_BLANK: begin
					if (sts.sweep_last) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

endmodule

// ===== tb/text_console_char_writer_checker.sv =====
// ----------------------------------------------------------------------------
// text_console_char_writer_checker
// Watches the item, result and attribute channels of the console writer,
// keeps its own copy of cursor, attribute and cell store, predicts each
// result in order and compares it field by field with what comes out.
// ----------------------------------------------------------------------------
module text_console_char_writer_checker
	import tcw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [ATTR_W-1:0] cfg_wr_data,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic              operation,
	input  logic [CHAR_W-1:0] char_code,
	input  logic [LOC_W-1:0]  cell_address,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [CELL_W-1:0] read_data,
	input  logic [ROW_W-1:0]  cursor_row,
	input  logic [COL_W-1:0]  cursor_col,
	input  logic [LOC_W-1:0]  cursor_location,
	input  logic              scrolled,
	output int                fail_count,
	output int                expected_left
);

	localparam logic [CHAR_W-1:0] HIGH_CHAR_FIRST = 8'h80;

	typedef struct packed {
		logic [CELL_W-1:0] data;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic [LOC_W-1:0]  loc;
		logic              scroll;
	} console_view_t;

	console_view_t     expected_views [$];
	logic [CELL_W-1:0] shadow_cells [CELLS];
	logic [ATTR_W-1:0] shadow_attr;
	int                cur_row;
	int                cur_col;

	task automatic predict_item(input logic op, input logic [CHAR_W-1:0] ch,
		input logic [LOC_W-1:0] addr);
		console_view_t v;
		int i;
		v = '0;
		if (op == OP_READ) begin
			if (int'(addr) < CELLS)
				v.data = shadow_cells[addr];
		end else begin
			if (ch == NEWLINE_CHAR) begin
				cur_col = 0;
				cur_row++;
			end else if (ch >= BLANK_CHAR && ch < HIGH_CHAR_FIRST) begin
				shadow_cells[cur_row * COLUMNS + cur_col] = {shadow_attr, ch};
				cur_col++;
			end
			if (cur_col >= COLUMNS) begin
				cur_col = 0;
				cur_row++;
			end
			if (cur_row >= ROWS) begin
				for (i = 0; i < CELLS - COLUMNS; i++)
					shadow_cells[i] = shadow_cells[i + COLUMNS];
				for (i = CELLS - COLUMNS; i < CELLS; i++)
					shadow_cells[i] = {shadow_attr, BLANK_CHAR};
				cur_row = ROWS - 1;
				v.scroll = 1'b1;
			end
		end
		v.row = ROW_W'(cur_row);
		v.col = COL_W'(cur_col);
		v.loc = LOC_W'(cur_row * COLUMNS + cur_col);
		expected_views.push_back(v);
	endtask

	function automatic int compare_view(console_view_t want, console_view_t got);
		int bad;
		bad = 0;
		if (got.data !== want.data) begin
			$error("read_data: expected %h, got %h", want.data, got.data);
			bad++;
		end
		if (got.row !== want.row) begin
			$error("cursor_row: expected %0d, got %0d", want.row, got.row);
			bad++;
		end
		if (got.col !== want.col) begin
			$error("cursor_col: expected %0d, got %0d", want.col, got.col);
			bad++;
		end
		if (got.loc !== want.loc) begin
			$error("cursor_location: expected %0d, got %0d", want.loc, got.loc);
			bad++;
		end
		if (got.scroll !== want.scroll) begin
			$error("scrolled: expected %b, got %b", want.scroll, got.scroll);
			bad++;
		end
		return bad;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		console_view_t got;
		int bad;
		int i;
		if (!arst_n) begin
			expected_views.delete();
			for (i = 0; i < CELLS; i++)
				shadow_cells[i] = '0;
			shadow_attr = ATTR_RESET;
			cur_row = 0;
			cur_col = 0;
			fail_count <= 0;
			expected_left <= 0;
		end else begin
			bad = 0;
			if (cfg_wr_en)
				shadow_attr = cfg_wr_data;
			if (out_valid && !out_stall) begin
				got = {read_data, cursor_row, cursor_col, cursor_location, scrolled};
				if (expected_views.size() == 0) begin
					$error("result with no item outstanding: read_data %h, location %0d",
						read_data, cursor_location);
					bad = 1;
				end else begin
					bad = compare_view(expected_views.pop_front(), got);
				end
			end
			if (in_valid && !in_stall)
				predict_item(operation, char_code, cell_address);
			fail_count <= fail_count + bad;
			expected_left <= expected_views.size();
		end
	end

endmodule

// ===== tb/tb_text_console_char_writer_top.sv =====
// ----------------------------------------------------------------------------
// tb_text_console_char_writer_top
// Drives the console writer with a short directed list (cleared cells,
// printable and ignored bytes, newline, reads past the store) and then with
// random text lines of varying length under several attribute settings,
// including a phase of very short lines that scrolls over and over.
// Items come in bursts with random gaps, results are stalled in changing
// patterns; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_text_console_char_writer_top
	import tcw_pkg::*;
();

	localparam longint RUN_LIMIT    = 36_000_000;
	localparam int     PHASES       = 7;
	localparam int     PHASE_ITEMS  = 200;
	localparam int     SCROLL_PHASE = 3;

	typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_style_t;

	logic              clk;
	logic              arst_n       = 1'b0;
	logic              cfg_wr_en    = 1'b0;
	logic [ATTR_W-1:0] cfg_wr_data  = '0;
	logic              in_valid     = 1'b0;
	logic              in_stall;
	logic              operation    = OP_PUT;
	logic [CHAR_W-1:0] char_code    = '0;
	logic [LOC_W-1:0]  cell_address = '0;
	logic              out_valid;
	logic              out_stall    = 1'b0;
	logic [CELL_W-1:0] read_data;
	logic [ROW_W-1:0]  cursor_row;
	logic [COL_W-1:0]  cursor_col;
	logic [LOC_W-1:0]  cursor_location;
	logic              scrolled;
	int                fail_count;
	int                expected_left;

	stall_style_t      stall_style = STALL_NONE;
	int                stall_hold  = 0;
	int                burst_left  = 0;
	int                typed       = 0;

	text_console_char_writer_top dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.operation       (operation),
		.char_code       (char_code),
		.cell_address    (cell_address),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.read_data       (read_data),
		.cursor_row      (cursor_row),
		.cursor_col      (cursor_col),
		.cursor_location (cursor_location),
		.scrolled        (scrolled)
	);

	text_console_char_writer_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.operation       (operation),
		.char_code       (char_code),
		.cell_address    (cell_address),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.read_data       (read_data),
		.cursor_row      (cursor_row),
		.cursor_col      (cursor_col),
		.cursor_location (cursor_location),
		.scrolled        (scrolled),
		.fail_count      (fail_count),
		.expected_left   (expected_left)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	// result side stalls in styles that change at random intervals
	always @(posedge clk) begin
		if (stall_hold == 0) begin
			stall_style <= stall_style_t'($urandom_range(0, 3));
			stall_hold <= $urandom_range(20, 300);
		end else begin
			stall_hold <= stall_hold - 1;
		end
		case (stall_style)
			STALL_NONE:     out_stall <= 1'b0;
			STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
			STALL_PERIODIC: out_stall <= ((stall_hold % 5) < 2);
			default:        out_stall <= 1'b0;
		endcase
	end

	task automatic offer(input logic op, input logic [CHAR_W-1:0] ch,
		input logic [LOC_W-1:0] addr);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		in_valid <= 1'b1;
		operation <= op;
		char_code <= ch;
		cell_address <= addr;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_left != 0);
		repeat (4) @(posedge clk);
		burst_left = 0;
	endtask

	task automatic set_attribute(input logic [ATTR_W-1:0] attr);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= attr;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [LOC_W-1:0] random_addr();
		int pick;
		pick = $urandom_range(0, 19);
		if (pick < 10)
			return LOC_W'($urandom_range(0, CELLS - 1));
		else if (pick < 15)
			return LOC_W'($urandom_range(CELLS - 2 * COLUMNS, CELLS - 1));
		else if (pick < 18)
			return LOC_W'($urandom_range(0, 2 * COLUMNS - 1));
		else
			return LOC_W'($urandom_range(CELLS, 2 ** LOC_W - 1));
	endfunction

	function automatic logic [CHAR_W-1:0] noise_char();
		logic [CHAR_W-1:0] c;
		if ($urandom_range(0, 1) == 0)
			c = CHAR_W'($urandom_range(0, 31));
		else
			c = CHAR_W'($urandom_range(128, 255));
		if (c == NEWLINE_CHAR)
			c = 8'h0B;
		return c;
	endfunction

	task automatic type_line(input int length);
		int k;
		for (k = 0; k < length; k++) begin
			if ($urandom_range(0, 19) == 0) begin
				offer(OP_PUT, noise_char(), LOC_W'($urandom));
			end else if ($urandom_range(0, 4) == 0) begin
				offer(OP_READ, CHAR_W'($urandom), random_addr());
				typed++;
			end else begin
				offer(OP_PUT, CHAR_W'($urandom_range(32, 127)), LOC_W'($urandom));
				typed++;
			end
		end
	endtask

	initial begin : stimulus
		int ph;
		int phase_start;
		int len;
		logic [ATTR_W-1:0] attr;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: cleared store, printable edges, ignored bytes, newline, reads
		offer(OP_READ, 8'h00, 11'd0);
		offer(OP_PUT, 8'h41, 11'h7FF);
		offer(OP_PUT, BLANK_CHAR, 11'd0);
		offer(OP_PUT, 8'h7F, 11'd0);
		offer(OP_PUT, 8'h1F, 11'd0);
		offer(OP_PUT, 8'h00, 11'd0);
		offer(OP_PUT, 8'h80, 11'd0);
		offer(OP_PUT, 8'hFF, 11'd0);
		offer(OP_PUT, NEWLINE_CHAR, 11'd0);
		offer(OP_PUT, 8'h7E, 11'd0);
		offer(OP_PUT, NEWLINE_CHAR, 11'd0);
		offer(OP_PUT, NEWLINE_CHAR, 11'd0);
		offer(OP_READ, 8'hFF, 11'd0);
		offer(OP_READ, 8'h00, 11'd1);
		offer(OP_READ, 8'h00, 11'd2);
		offer(OP_READ, 8'h00, 11'd3);
		offer(OP_READ, 8'h00, COLUMNS_L);
		offer(OP_READ, 8'h00, CELL_LAST_L);
		offer(OP_READ, 8'h00, CELLS_L);
		offer(OP_READ, 8'h00, 11'h7FF);

		for (ph = 0; ph < PHASES; ph++) begin
			settle();
			if (ph == 0)
				attr = 8'h00;
			else if (ph == 1)
				attr = 8'hFF;
			else
				attr = ATTR_W'($urandom_range(0, 255));
			set_attribute(attr);
			phase_start = typed;
			while (typed - phase_start < PHASE_ITEMS) begin
				if (ph == SCROLL_PHASE) begin
					len = $urandom_range(0, 3);
				end else begin
					case ($urandom_range(0, 9))
						0:       len = $urandom_range(75, 90);
						1:       len = $urandom_range(0, 2);
						default: len = $urandom_range(3, 30);
					endcase
				end
				type_line(len);
				if ($urandom_range(0, 7) != 0) begin
					offer(OP_PUT, NEWLINE_CHAR, LOC_W'($urandom));
					typed++;
				end
			end
		end

		in_valid <= 1'b0;
		do @(posedge clk); while (expected_left != 0);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
